/* sv/clt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the C-like text tokenizer
// Token kinds, scanner modes, character codes and result queue sizing.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int Q_DEPTH     = MAX_RESULTS + 1;
    localparam int Q_IDX_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef logic [3:0] t_kind;

    localparam t_kind K_LPAREN  = 4'd0;
    localparam t_kind K_RPAREN  = 4'd1;
    localparam t_kind K_SEMI    = 4'd2;
    localparam t_kind K_COLON   = 4'd3;
    localparam t_kind K_STAR    = 4'd4;
    localparam t_kind K_LBRACK  = 4'd5;
    localparam t_kind K_RBRACK  = 4'd6;
    localparam t_kind K_LBRACE  = 4'd7;
    localparam t_kind K_RBRACE  = 4'd8;
    localparam t_kind K_STRING  = 4'd9;
    localparam t_kind K_IDENT   = 4'd10;
    localparam t_kind K_NUMERIC = 4'd11;
    localparam t_kind K_UNKNOWN = 4'd12;
    localparam t_kind K_END     = 4'd13;

    typedef enum logic [3:0] {
        M_NORMAL,
        M_LINE,
        M_BLK_OPEN,
        M_BLK,
        M_BLK_CLOSE,
        M_STR,
        M_STR_ESC,
        M_IDENT,
        M_IDENT_COLON
    } t_mode;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_USCORE = 8'h5F;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;

    function automatic logic f_is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic f_is_nl(input logic [7:0] c);
        return c == C_NL || c == C_CR;
    endfunction

    // kind of a single-character token: punctuation, numeric or unknown
    function automatic t_kind f_char_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            C_LPAREN: k = K_LPAREN;
            C_RPAREN: k = K_RPAREN;
            C_SEMI:   k = K_SEMI;
            C_COLON:  k = K_COLON;
            C_STAR:   k = K_STAR;
            C_LBRACK: k = K_LBRACK;
            C_RBRACK: k = K_RBRACK;
            C_LBRACE: k = K_LBRACE;
            C_RBRACE: k = K_RBRACE;
            default:  k = f_is_digit(c) ? K_NUMERIC : K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

/* sv/clt_outq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_outq: token result queue
// Holds the tokens of up to two bytes and hands them out one word a cycle on tready.
// ----------------------------------------------------------------------------
module clt_outq #(
    parameter int DATA_W = 80
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire logic [clt_pkg::RES_CNT_W-1:0] i_load_cnt,
    input  wire logic [DATA_W-1:0]          i_load_data [clt_pkg::MAX_RESULTS],
    input  wire clt_pkg::t_kind             i_load_kind [clt_pkg::MAX_RESULTS],
    output logic                            o_space,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [DATA_W-1:0]               o_m_tdata,  // offset, length, line, column
    output clt_pkg::t_kind                  o_m_tuser,  // token kind
    output logic                            o_m_tlast
);
    import clt_pkg::*;

    logic [DATA_W-1:0]  r_data [Q_DEPTH];
    t_kind              r_kind [Q_DEPTH];
    logic               r_last [Q_DEPTH];
    logic [DATA_W-1:0]  n_data [Q_DEPTH];
    t_kind              n_kind [Q_DEPTH];
    logic               n_last [Q_DEPTH];
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;
    logic               take;
    logic [Q_CNT_W-1:0] base;

    always_comb begin
        take  = (r_cnt != '0) && i_m_tready;
        base  = r_cnt - Q_CNT_W'(take);
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (take && i < Q_DEPTH - 1) begin
                n_data[i] = r_data[i+1];
                n_kind[i] = r_kind[i+1];
                n_last[i] = r_last[i+1];
            end else begin
                n_data[i] = r_data[i];
                n_kind[i] = r_kind[i];
                n_last[i] = r_last[i];
            end
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (i_load && RES_CNT_W'(k) < i_load_cnt
                        && base + Q_CNT_W'(k) == Q_CNT_W'(i)) begin
                    n_data[i] = i_load_data[k];
                    n_kind[i] = i_load_kind[k];
                    n_last[i] = (RES_CNT_W'(k + 1) == i_load_cnt);
                end
            end
        end
        n_cnt = base + (i_load ? Q_CNT_W'(i_load_cnt) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_data <= n_data;
        r_kind <= n_kind;
        r_last <= n_last;
    end

    assign o_space    = base <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS);
    assign o_m_tvalid = r_cnt != '0;
    assign o_m_tdata  = r_data[0];
    assign o_m_tuser  = r_kind[0];
    assign o_m_tlast  = r_last[0];

endmodule
`default_nettype wire

/* sv/c_like_text_tokenizer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_like_text_tokenizer_top: streaming lexer for C-like source text
// Skips whitespace, comments and directive lines and reports tokens with
// their offset, length, line and column; a zero byte closes each text.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle. Each byte is scanned when the byte after
// it arrives, so a token is loaded into the result queue as that next byte is
// taken and leaves from the queue head, later while older tokens still wait.
// A byte gives up to three tokens, handed out one word a cycle on tready
// from a four-entry result queue; input is held off only while that queue has
// more than one token left over, so bursts of multi-token bytes set the rate.
// After the end token every counter starts again from line 1, column 0.
module c_like_text_tokenizer_top #(
    parameter int OFFSET_BITS = clt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = clt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = clt_pkg::COLUMN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // text_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // start_offset, token_length, start_line, start_column
    output logic [((OFFSET_BITS + clt_pkg::LEN_BITS + LINE_BITS + COLUMN_BITS + 7) / 8) * 8 - 1:0]
                             o_m_tdata,
    output clt_pkg::t_kind   o_m_tuser,   // token_kind
    output logic             o_m_tlast    // last_in_run
);
    import clt_pkg::*;

    localparam int FIELDS_W = OFFSET_BITS + LEN_BITS + LINE_BITS + COLUMN_BITS;
    localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8;
    localparam int LEN_LSB  = OFFSET_BITS;
    localparam int LINE_LSB = OFFSET_BITS + LEN_BITS;
    localparam int COL_LSB  = OFFSET_BITS + LEN_BITS + LINE_BITS;
    localparam int N_CAND   = MAX_RESULTS + 1;

    t_mode                  r_mode,    n_mode;
    logic [7:0]             r_held,    n_held;
    logic                   r_held_vld, n_held_vld;
    logic [OFFSET_BITS-1:0] r_off,     n_off;
    logic [LINE_BITS-1:0]   r_line,    n_line;
    logic [COLUMN_BITS-1:0] r_col,     n_col;
    logic [OFFSET_BITS-1:0] r_ts_off,  n_ts_off;
    logic [LINE_BITS-1:0]   r_ts_line, n_ts_line;
    logic [COLUMN_BITS-1:0] r_ts_col,  n_ts_col;
    logic [LEN_BITS-1:0]    r_tok_len, n_tok_len;

    logic                   accept;
    logic                   space;
    logic [RES_CNT_W-1:0]   ld_cnt;
    logic [DATA_W-1:0]      ld_data [MAX_RESULTS];
    t_kind                  ld_kind [MAX_RESULTS];

    always_comb begin
        logic [7:0]             c;
        logic [7:0]             nb;
        logic                   do_normal;
        logic [OFFSET_BITS-1:0] adv_off;
        logic [LINE_BITS-1:0]   adv_line;
        logic [COLUMN_BITS-1:0] adv_col;
        logic [LEN_BITS-1:0]    len_inc;
        logic                   e_vld  [N_CAND];
        t_kind                  e_kind [N_CAND];
        logic [OFFSET_BITS-1:0] e_off  [N_CAND];
        logic [LEN_BITS-1:0]    e_len  [N_CAND];
        logic [LINE_BITS-1:0]   e_line [N_CAND];
        logic [COLUMN_BITS-1:0] e_col  [N_CAND];
        logic [DATA_W-1:0]      word;

        c         = r_held;
        nb        = i_s_tdata;
        do_normal = 1'b0;
        adv_off   = (r_off == '1) ? r_off : r_off + 1'b1;
        adv_col   = f_is_nl(c) ? '0 : ((r_col == '1) ? r_col : r_col + 1'b1);
        adv_line  = (f_is_nl(c) && r_line != '1) ? r_line + 1'b1 : r_line;
        len_inc   = (r_tok_len == LEN_MAX) ? r_tok_len : r_tok_len + 1'b1;

        for (int j = 0; j < N_CAND; j++) begin
            e_vld[j]  = 1'b0;
            e_kind[j] = K_END;
            e_off[j]  = r_off;
            e_len[j]  = LEN_BITS'(1);
            e_line[j] = r_line;
            e_col[j]  = r_col;
        end

        n_mode     = r_mode;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_off      = r_off;
        n_line     = r_line;
        n_col      = r_col;
        n_ts_off   = r_ts_off;
        n_ts_line  = r_ts_line;
        n_ts_col   = r_ts_col;
        n_tok_len  = r_tok_len;

        if (accept && r_held_vld) begin
            n_off  = adv_off;
            n_line = adv_line;
            n_col  = adv_col;
            unique case (r_mode)
                M_LINE: begin
                    if (f_is_nl(c)) begin
                        n_mode = M_NORMAL;
                    end
                end
                M_BLK_OPEN: n_mode = M_BLK;
                M_BLK: begin
                    if (c == C_STAR && nb == C_SLASH) begin
                        n_mode = M_BLK_CLOSE;
                    end
                end
                M_BLK_CLOSE: n_mode = M_NORMAL;
                M_STR: begin
                    if (c == C_QUOTE) begin
                        e_vld[0]  = 1'b1;
                        e_kind[0] = K_STRING;
                        n_mode    = M_NORMAL;
                    end else begin
                        n_tok_len = len_inc;
                        if (c == C_BSLASH && nb != C_NUL) begin
                            n_mode = M_STR_ESC;
                        end
                    end
                end
                M_STR_ESC: begin
                    n_tok_len = len_inc;
                    n_mode    = M_STR;
                end
                M_IDENT: begin
                    if (f_is_letter(c) || f_is_digit(c) || c == C_USCORE) begin
                        n_tok_len = len_inc;
                    end else if (c == C_COLON && nb == C_COLON) begin
                        n_tok_len = len_inc;
                        n_mode    = M_IDENT_COLON;
                    end else begin
                        e_vld[0]  = 1'b1;
                        e_kind[0] = K_IDENT;
                        do_normal = 1'b1;
                    end
                end
                M_IDENT_COLON: begin
                    n_tok_len = len_inc;
                    n_mode    = M_IDENT;
                end
                default: do_normal = 1'b1;
            endcase

            if (do_normal) begin
                n_mode = M_NORMAL;
                priority if (c == C_SPACE || c == C_TAB || f_is_nl(c)) begin
                    n_mode = M_NORMAL;
                end else if (c == C_SLASH && nb == C_SLASH) begin
                    n_mode = M_LINE;
                end else if (c == C_SLASH && nb == C_STAR) begin
                    n_mode = M_BLK_OPEN;
                end else if (c == C_HASH) begin
                    n_mode = M_LINE;
                end else if (c == C_QUOTE) begin
                    n_ts_off  = adv_off;
                    n_ts_line = adv_line;
                    n_ts_col  = adv_col;
                    n_tok_len = '0;
                    n_mode    = M_STR;
                end else if (f_is_letter(c)) begin
                    n_ts_off  = r_off;
                    n_ts_line = r_line;
                    n_ts_col  = r_col;
                    n_tok_len = LEN_BITS'(1);
                    n_mode    = M_IDENT;
                end else begin
                    e_vld[1]  = 1'b1;
                    e_kind[1] = f_char_kind(c);
                end
            end
        end

        e_off[0]  = r_ts_off;
        e_len[0]  = r_tok_len;
        e_line[0] = r_ts_line;
        e_col[0]  = r_ts_col;

        if (accept) begin
            if (nb == C_NUL) begin
                e_off[2]  = n_ts_off;
                e_len[2]  = n_tok_len;
                e_line[2] = n_ts_line;
                e_col[2]  = n_ts_col;
                if (n_mode == M_STR || n_mode == M_STR_ESC) begin
                    e_vld[2]  = 1'b1;
                    e_kind[2] = K_STRING;
                end else if (n_mode == M_IDENT || n_mode == M_IDENT_COLON) begin
                    e_vld[2]  = 1'b1;
                    e_kind[2] = K_IDENT;
                end
                e_vld[3]   = 1'b1;
                e_kind[3]  = K_END;
                e_off[3]   = n_off;
                e_line[3]  = n_line;
                e_col[3]   = n_col;
                n_mode     = M_NORMAL;
                n_held_vld = 1'b0;
                n_off      = '0;
                n_line     = LINE_BITS'(1);
                n_col      = '0;
                n_ts_off   = '0;
                n_ts_line  = LINE_BITS'(1);
                n_ts_col   = '0;
                n_tok_len  = '0;
            end else begin
                n_held     = nb;
                n_held_vld = 1'b1;
            end
        end

        // pack the candidates in order into the load slots
        ld_cnt = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            ld_data[k] = '0;
            ld_kind[k] = K_END;
        end
        for (int j = 0; j < N_CAND; j++) begin
            word = '0;
            word[OFFSET_BITS-1:0]          = e_off[j];
            word[LEN_LSB +: LEN_BITS]      = e_len[j];
            word[LINE_LSB +: LINE_BITS]    = e_line[j];
            word[COL_LSB +: COLUMN_BITS]   = e_col[j];
            if (e_vld[j] && ld_cnt < RES_CNT_W'(MAX_RESULTS)) begin
                ld_data[ld_cnt] = word;
                ld_kind[ld_cnt] = e_kind[j];
                ld_cnt          = ld_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_NORMAL;
            r_held_vld <= 1'b0;
            r_off      <= '0;
            r_line     <= LINE_BITS'(1);
            r_col      <= '0;
            r_ts_off   <= '0;
            r_ts_line  <= LINE_BITS'(1);
            r_ts_col   <= '0;
            r_tok_len  <= '0;
        end else begin
            r_mode     <= n_mode;
            r_held_vld <= n_held_vld;
            r_off      <= n_off;
            r_line     <= n_line;
            r_col      <= n_col;
            r_ts_off   <= n_ts_off;
            r_ts_line  <= n_ts_line;
            r_ts_col   <= n_ts_col;
            r_tok_len  <= n_tok_len;
        end
        r_held <= n_held;
    end

    assign o_s_tready = space;
    assign accept     = i_s_tvalid && space;

    clt_outq #(
        .DATA_W (DATA_W)
    ) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_load_cnt  (ld_cnt),
        .i_load_data (ld_data),
        .i_load_kind (ld_kind),
        .o_space     (space),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_held_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_vld |-> r_held != C_NUL)
        else $error("held byte is zero");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_tdata == C_NUL |=> r_mode == M_NORMAL && !r_held_vld
            && r_off == '0 && r_col == '0 && r_line == LINE_BITS'(1))
        else $error("scanner not restarted after end of text");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_ts_line != '0)
        else $error("line count reached zero");

    a_end_token_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == K_END |-> o_m_tlast)
        else $error("end token not marked last");
`endif

endmodule
`default_nettype wire
